// File: rtl/core/packet_message_deframer_assert.svh
// Assertion macros for the packet message deframer.
`ifndef PACKET_MESSAGE_DEFRAMER_ASSERT_SVH
`define PACKET_MESSAGE_DEFRAMER_ASSERT_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define PMD_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define PMD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define PMD_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define PMD_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// File: rtl/core/pmd_pkg.sv
// Shared types and constants for the packet message deframer.
package pmd_pkg;

   localparam int SESSION_BYTES  = 10;
   localparam int SEQUENCE_BYTES = 8;
   localparam int COUNT_BYTES    = 2;
   localparam int HEADER_BYTES   = SESSION_BYTES + SEQUENCE_BYTES + COUNT_BYTES;

   localparam int HDR_CNT_W = 5;
   localparam int SEQ_W     = 64;
   localparam int LEN_W     = 16;

   localparam logic [HDR_CNT_W-1:0] SEQ_FIRST = HDR_CNT_W'(SESSION_BYTES);
   localparam logic [HDR_CNT_W-1:0] SEQ_LAST  =
      HDR_CNT_W'(SESSION_BYTES + SEQUENCE_BYTES - 1);
   localparam logic [HDR_CNT_W-1:0] CNT_HI    = HDR_CNT_W'(SESSION_BYTES + SEQUENCE_BYTES);
   localparam logic [HDR_CNT_W-1:0] HDR_LAST  = HDR_CNT_W'(HEADER_BYTES - 1);

   typedef enum logic [2:0] {
      PH_HEADER = 3'd0,
      PH_LEN_HI = 3'd1,
      PH_LEN_LO = 3'd2,
      PH_TYPE   = 3'd3,
      PH_BODY   = 3'd4,
      PH_DROP   = 3'd5
   } pmd_phase_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_HDR_SHORT = 2'd1,
      ST_MISSING   = 2'd2,
      ST_TRUNC     = 2'd3
   } pmd_status_type;

   typedef struct packed {
      logic [7:0]       msg_byte;
      logic             msg_first;
      logic             msg_last;
      logic [LEN_W-1:0] msg_index;
      logic [SEQ_W-1:0] packet_sequence;
      pmd_status_type   status;
   } pmd_result_type;

   typedef struct packed {
      pmd_phase_type        phase;
      logic [HDR_CNT_W-1:0] hdr_cnt;
   } pmd_parse_status_type;

endpackage

// File: rtl/core/packet_message_deframer.sv
// Packet message deframer top level. Takes a datagram payload one byte per
// cycle unless stalled, parses the 20-byte header (session, big-endian sequence,
// message count) and splits the messages that follow, each a 16-bit big-endian
// length and its bytes. Every message byte leaves with first/last marks, its
// message index and the packet sequence; short packets and zero lengths give an
// error item. One byte is accepted every cycle while req_stall is low; results
// are registered in a two-entry output buffer, and req_stall rises only while
// both entries are held by a stalled result channel.
module packet_message_deframer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_payload_byte,
   input  logic        req_packet_end,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_msg_byte,
   output logic        rsp_msg_first,
   output logic        rsp_msg_last,
   output logic [15:0] rsp_msg_index,
   output logic [63:0] rsp_packet_sequence,
   output logic [1:0]  rsp_status
);
   import pmd_pkg::*;

`include "packet_message_deframer_assert.svh"

   logic                 accept;
   logic                 res_push;
   pmd_result_type       res_data;
   pmd_result_type       rsp_data;
   pmd_parse_status_type parse_status;
   logic                 past_header;
   logic                 hdr_complete;
   logic                 err_item;
   logic                 err_clear;
   logic                 short_item;
   logic                 short_clear;

   assign accept = req_valid & ~req_stall;

   pmd_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .payload_byte (req_payload_byte),
      .packet_end   (req_packet_end),
      .res_push     (res_push),
      .res_data     (res_data),
      .parse_status (parse_status)
   );

   pmd_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .full      (req_stall)
   );

   assign rsp_msg_byte        = rsp_data.msg_byte;
   assign rsp_msg_first       = rsp_data.msg_first;
   assign rsp_msg_last        = rsp_data.msg_last;
   assign rsp_msg_index       = rsp_data.msg_index;
   assign rsp_packet_sequence = rsp_data.packet_sequence;
   assign rsp_status          = rsp_data.status;

   assign past_header  = parse_status.phase != PH_HEADER;
   assign hdr_complete = parse_status.hdr_cnt == HDR_LAST;
   assign err_item     = rsp_valid && (rsp_status == ST_HDR_SHORT || rsp_status == ST_TRUNC);
   assign err_clear    = rsp_msg_byte == 8'h00 && !rsp_msg_first && !rsp_msg_last;
   assign short_item   = rsp_valid && rsp_status == ST_HDR_SHORT;
   assign short_clear  = rsp_msg_index == '0 && rsp_packet_sequence == '0;

   `PMD_ASSERT_IMPLY(a_hdr_done, clock, reset, past_header, hdr_complete, "header left early")
   `PMD_ASSERT_IMPLY(a_err_empty, clock, reset, err_item, err_clear, "error item has data")
   `PMD_ASSERT_IMPLY(a_short_zero, clock, reset, short_item, short_clear, "short item not zero")

endmodule

// File: rtl/core/pmd_parser.sv
// Header and message framing state with the per-byte result logic.
module pmd_parser (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic [7:0]                  payload_byte,
   input  logic                        packet_end,
   output logic                        res_push,
   output pmd_pkg::pmd_result_type     res_data,
   output pmd_pkg::pmd_parse_status_type parse_status
);
   import pmd_pkg::*;

   pmd_phase_type        phase_ff, phase_in;
   logic [HDR_CNT_W-1:0] hdr_cnt_ff, hdr_cnt_in;
   logic [SEQ_W-1:0]     seq_ff, seq_in;
   logic [LEN_W-1:0]     msgs_left_ff, msgs_left_in;
   logic [LEN_W-1:0]     msg_num_ff, msg_num_in;
   logic [LEN_W-1:0]     bytes_left_ff, bytes_left_in;
   logic                 res_valid;
   logic [LEN_W-1:0]     len_full;
   logic [LEN_W-1:0]     bytes_dec;
   logic [LEN_W-1:0]     msgs_dec;

   assign len_full  = {bytes_left_ff[LEN_W-1:8], payload_byte};
   assign bytes_dec = bytes_left_ff - LEN_W'(1);
   assign msgs_dec  = msgs_left_ff - LEN_W'(1);

   always_comb begin
      phase_in      = phase_ff;
      hdr_cnt_in    = hdr_cnt_ff;
      seq_in        = seq_ff;
      msgs_left_in  = msgs_left_ff;
      msg_num_in    = msg_num_ff;
      bytes_left_in = bytes_left_ff;
      res_valid     = 1'b0;
      res_data.msg_byte        = '0;
      res_data.msg_first       = 1'b0;
      res_data.msg_last        = 1'b0;
      res_data.msg_index       = msg_num_ff;
      res_data.packet_sequence = seq_ff;
      res_data.status          = ST_OK;

      case (phase_ff)
         PH_HEADER: begin
            if (hdr_cnt_ff >= SEQ_FIRST && hdr_cnt_ff <= SEQ_LAST) begin
               seq_in = {seq_ff[SEQ_W-9:0], payload_byte};
            end else if (hdr_cnt_ff == CNT_HI) begin
               msgs_left_in = {payload_byte, 8'h00};
            end else if (hdr_cnt_ff == HDR_LAST) begin
               msgs_left_in = {msgs_left_ff[LEN_W-1:8], payload_byte};
            end
            if (hdr_cnt_ff >= HDR_LAST) begin
               msg_num_in = '0;
               phase_in   = (msgs_left_in == '0) ? PH_DROP : PH_LEN_HI;
               if (packet_end && msgs_left_in != '0) begin
                  res_valid          = 1'b1;
                  res_data.msg_index = '0;
                  res_data.status    = ST_MISSING;
               end
            end else begin
               hdr_cnt_in = hdr_cnt_ff + HDR_CNT_W'(1);
               if (packet_end) begin
                  res_valid                = 1'b1;
                  res_data.msg_index       = '0;
                  res_data.packet_sequence = '0;
                  res_data.status          = ST_HDR_SHORT;
               end
            end
         end
         PH_LEN_HI: begin
            bytes_left_in = {payload_byte, 8'h00};
            phase_in      = PH_LEN_LO;
            if (packet_end) begin
               res_valid       = 1'b1;
               res_data.status = ST_MISSING;
            end
         end
         PH_LEN_LO: begin
            bytes_left_in = len_full;
            if (len_full == '0) begin
               phase_in        = PH_DROP;
               res_valid       = 1'b1;
               res_data.status = ST_TRUNC;
            end else begin
               phase_in = PH_TYPE;
               if (packet_end) begin
                  res_valid       = 1'b1;
                  res_data.status = ST_TRUNC;
               end
            end
         end
         PH_TYPE, PH_BODY: begin
            bytes_left_in = bytes_dec;
            res_valid     = 1'b1;
            if (bytes_dec == '0) begin
               msg_num_in         = msg_num_ff + LEN_W'(1);
               msgs_left_in       = msgs_dec;
               phase_in           = (msgs_dec == '0) ? PH_DROP : PH_LEN_HI;
               res_data.msg_byte  = payload_byte;
               res_data.msg_first = (phase_ff == PH_TYPE);
               res_data.msg_last  = 1'b1;
               res_data.status    = (packet_end && msgs_dec != '0) ? ST_MISSING : ST_OK;
            end else begin
               phase_in = PH_BODY;
               if (packet_end) begin
                  res_data.status = ST_TRUNC;
               end else begin
                  res_data.msg_byte  = payload_byte;
                  res_data.msg_first = (phase_ff == PH_TYPE);
               end
            end
         end
         PH_DROP: begin
         end
         default: begin
         end
      endcase

      if (packet_end) begin
         phase_in   = PH_HEADER;
         hdr_cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HEADER;
         hdr_cnt_ff    <= '0;
         seq_ff        <= '0;
         msgs_left_ff  <= '0;
         msg_num_ff    <= '0;
         bytes_left_ff <= '0;
      end else if (accept) begin
         phase_ff      <= phase_in;
         hdr_cnt_ff    <= hdr_cnt_in;
         seq_ff        <= seq_in;
         msgs_left_ff  <= msgs_left_in;
         msg_num_ff    <= msg_num_in;
         bytes_left_ff <= bytes_left_in;
      end
   end

   assign res_push             = accept & res_valid;
   assign parse_status.phase   = phase_ff;
   assign parse_status.hdr_cnt = hdr_cnt_ff;

endmodule

// File: rtl/core/pmd_out_buf.sv
// Two-entry result buffer: output register plus skid entry.
module pmd_out_buf (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  pmd_pkg::pmd_result_type push_data,
   input  logic                    rsp_stall,
   output logic                    rsp_valid,
   output pmd_pkg::pmd_result_type rsp_data,
   output logic                    full
);
   import pmd_pkg::*;

   logic           main_valid_ff, main_valid_in;
   logic           skid_valid_ff, skid_valid_in;
   pmd_result_type main_data_ff, main_data_in;
   pmd_result_type skid_data_ff, skid_data_in;
   logic           pop;

   assign pop = main_valid_ff & ~rsp_stall;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_data_in  = main_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            main_data_in  = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || pop) begin
            main_data_in  = push_data;
            main_valid_in = 1'b1;
         end else begin
            skid_data_in  = push_data;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = main_valid_ff;
   assign rsp_data  = main_data_ff;
   assign full      = skid_valid_ff;

endmodule

// File: tb/pmd_scoreboard_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the packet message deframer: byte-level deframing predictor and item check.
package pmd_scoreboard_pkg;
   import pmd_pkg::*;

   class pmd_deframe_scoreboard;
      pmd_phase_type        phase;
      logic [HDR_CNT_W-1:0] hdr_count;
      logic [SEQ_W-1:0]     sequence_no;
      logic [LEN_W-1:0]     msgs_left;
      logic [LEN_W-1:0]     msg_number;
      logic [LEN_W-1:0]     bytes_left;
      pmd_result_type       message_items[$];
      int                   errors;

      function new();
         phase       = PH_HEADER;
         hdr_count   = '0;
         sequence_no = '0;
         msgs_left   = '0;
         msg_number  = '0;
         bytes_left  = '0;
         errors      = 0;
      endfunction

      // Notes one accepted payload byte and queues the item it causes, if any.
      function void deframe_byte(logic [7:0] b, logic last);
         pmd_result_type item;
         logic           produced;
         logic           first;
         item     = '0;
         produced = 1'b0;
         case (phase)
            PH_HEADER: begin
               if (hdr_count >= SEQ_FIRST && hdr_count <= SEQ_LAST)
                  sequence_no = {sequence_no[SEQ_W-9:0], b};
               else if (hdr_count == CNT_HI)
                  msgs_left = {b, 8'h00};
               else if (hdr_count == HDR_LAST)
                  msgs_left = msgs_left | {8'h00, b};
               if (hdr_count == HDR_LAST) begin
                  msg_number = '0;
                  phase = (msgs_left == 0) ? PH_DROP : PH_LEN_HI;
                  if (last && msgs_left != 0) begin
                     item.packet_sequence = sequence_no;
                     item.status = ST_MISSING;
                     produced = 1'b1;
                  end
               end else begin
                  hdr_count = hdr_count + HDR_CNT_W'(1);
                  if (last) begin
                     item.status = ST_HDR_SHORT;
                     produced = 1'b1;
                  end
               end
            end
            PH_LEN_HI: begin
               bytes_left = {b, 8'h00};
               phase = PH_LEN_LO;
               if (last) begin
                  item.msg_index = msg_number;
                  item.packet_sequence = sequence_no;
                  item.status = ST_MISSING;
                  produced = 1'b1;
               end
            end
            PH_LEN_LO: begin
               bytes_left = bytes_left | {8'h00, b};
               phase = (bytes_left == 0) ? PH_DROP : PH_TYPE;
               if (bytes_left == 0 || last) begin
                  item.msg_index = msg_number;
                  item.packet_sequence = sequence_no;
                  item.status = ST_TRUNC;
                  produced = 1'b1;
               end
            end
            PH_TYPE, PH_BODY: begin
               first = (phase == PH_TYPE);
               bytes_left = bytes_left - LEN_W'(1);
               produced = 1'b1;
               item.packet_sequence = sequence_no;
               if (bytes_left == 0) begin
                  item.msg_byte  = b;
                  item.msg_first = first;
                  item.msg_last  = 1'b1;
                  item.msg_index = msg_number;
                  msg_number = msg_number + LEN_W'(1);
                  msgs_left  = msgs_left - LEN_W'(1);
                  phase = (msgs_left == 0) ? PH_DROP : PH_LEN_HI;
                  item.status = (last && msgs_left != 0) ? ST_MISSING : ST_OK;
               end else begin
                  phase = PH_BODY;
                  item.msg_index = msg_number;
                  if (last) begin
                     item.status = ST_TRUNC;
                  end else begin
                     item.msg_byte  = b;
                     item.msg_first = first;
                     item.status    = ST_OK;
                  end
               end
            end
            default: ;
         endcase
         if (last) begin
            phase = PH_HEADER;
            hdr_count = '0;
         end
         if (produced)
            message_items.push_back(item);
      endfunction

      function void report_field(string name, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_message_item(pmd_result_type got);
         pmd_result_type want;
         if (message_items.size() == 0) begin
            $display("%0t: unexpected item, expected none, actual %h", $time, got);
            errors++;
            return;
         end
         want = message_items.pop_front();
         report_field("msg_byte", want.msg_byte, got.msg_byte);
         report_field("msg_first", want.msg_first, got.msg_first);
         report_field("msg_last", want.msg_last, got.msg_last);
         report_field("msg_index", want.msg_index, got.msg_index);
         report_field("packet_sequence", want.packet_sequence, got.packet_sequence);
         report_field("status", want.status, got.status);
      endfunction
   endclass

endpackage

// File: tb/packet_message_deframer_tb.sv
`timescale 1ns / 100ps
// Testbench for the packet message deframer: random datagrams, bursty sender, stalling sink.
module packet_message_deframer_tb;
   import pmd_pkg::*;
   import pmd_scoreboard_pkg::*;

   localparam int IDLE_LIMIT = 2000;
   localparam int ITEM_TARGET = 800;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_payload_byte = 8'h00;
   logic        req_packet_end = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_msg_byte;
   logic        rsp_msg_first;
   logic        rsp_msg_last;
   logic [15:0] rsp_msg_index;
   logic [63:0] rsp_packet_sequence;
   logic [1:0]  rsp_status;

   pmd_deframe_scoreboard sb;
   logic [7:0] datagram[$];
   int items_sent = 0;
   int burst_left = 0;
   int sink_mode = 0;
   int sink_mode_left = 0;
   int idle_cycles = 0;

   packet_message_deframer i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_payload_byte    (req_payload_byte),
      .req_packet_end      (req_packet_end),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_msg_byte        (rsp_msg_byte),
      .rsp_msg_first       (rsp_msg_first),
      .rsp_msg_last        (rsp_msg_last),
      .rsp_msg_index       (rsp_msg_index),
      .rsp_packet_sequence (rsp_packet_sequence),
      .rsp_status          (rsp_status)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // sink stall pattern: free, light, half, heavy
   always @(posedge clock) begin
      if (sink_mode_left == 0) begin
         sink_mode <= $urandom_range(0, 3);
         sink_mode_left <= $urandom_range(20, 200);
      end else begin
         sink_mode_left <= sink_mode_left - 1;
      end
      case (sink_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= 1'($urandom_range(0, 1));
         default: rsp_stall <= ($urandom_range(0, 7) != 0);
      endcase
   end

   always @(posedge clock) begin
      pmd_result_type got;
      logic           moved;
      moved = 1'b0;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            sb.deframe_byte(req_payload_byte, req_packet_end);
            moved = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            got.msg_byte        = rsp_msg_byte;
            got.msg_first       = rsp_msg_first;
            got.msg_last        = rsp_msg_last;
            got.msg_index       = rsp_msg_index;
            got.packet_sequence = rsp_packet_sequence;
            got.status          = pmd_status_type'(rsp_status);
            sb.check_message_item(got);
            moved = 1'b1;
         end
      end
      if (moved) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: timeout, no item moved for %0d cycles", $time, IDLE_LIMIT);
         $display("packet_message_deframer_tb: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = $urandom_range(1, 40);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_payload_byte <= b;
      req_packet_end <= last;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   // cut > 0 ends the datagram after that many bytes
   task automatic send_datagram(input int cut);
      int n;
      n = datagram.size();
      if (cut > 0 && cut < n)
         n = cut;
      for (int i = 0; i < n; i++)
         send_byte(datagram[i], i == n - 1);
   endtask

   task automatic add_noise(input int n);
      repeat (n) datagram.push_back(8'($urandom_range(0, 255)));
   endtask

   task automatic start_header(input logic [63:0] seq_no, input logic [15:0] count);
      datagram.delete();
      add_noise(SESSION_BYTES);
      for (int i = SEQUENCE_BYTES - 1; i >= 0; i--)
         datagram.push_back(seq_no[i*8 +: 8]);
      datagram.push_back(count[15:8]);
      datagram.push_back(count[7:0]);
   endtask

   task automatic add_message(input logic [15:0] len, input int body);
      datagram.push_back(len[15:8]);
      datagram.push_back(len[7:0]);
      add_noise(body);
   endtask

   initial begin
      int          kind;
      int          cnt;
      int          n_msgs;
      int          zero_at;
      int          len;
      int          cut;
      logic [63:0] seq_no;
      sb = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // header cut short, after the first byte and before the last header byte
      start_header({$urandom, $urandom}, 1);
      send_datagram(1);
      start_header(64'h0123_4567_89AB_CDEF, 2);
      send_datagram(HEADER_BYTES - 1);
      // zero count with trailing bytes
      start_header('1, 0);
      add_noise(3);
      send_datagram(0);
      // messages missing at end of header
      start_header('0, 16'hFFFF);
      send_datagram(0);
      // ends on a length high byte
      start_header({$urandom, $urandom}, 2);
      add_message(1, 1);
      add_message(16'hFF00, 0);
      send_datagram(HEADER_BYTES + 4);
      // ends on a length low byte
      start_header({$urandom, $urandom}, 1);
      add_message(16'h00FF, 0);
      send_datagram(0);
      // zero length drops the rest
      start_header({$urandom, $urandom}, 3);
      add_message(1, 1);
      add_message(0, 0);
      add_message(2, 2);
      send_datagram(0);
      // truncated body
      start_header({$urandom, $urandom}, 1);
      add_message(16'h0100, 5);
      send_datagram(0);
      // ends on a final message byte with messages still due
      start_header({$urandom, $urandom}, 3);
      add_message(2, 2);
      send_datagram(0);
      // clean packets, one with trailing bytes
      start_header('1, 2);
      add_message(1, 1);
      add_message(3, 3);
      datagram.push_back(8'h00);
      datagram.push_back(8'hFF);
      send_datagram(0);
      start_header({$urandom, $urandom}, 1);
      add_message(1, 1);
      send_datagram(0);

      while (items_sent < ITEM_TARGET) begin
         kind = $urandom_range(0, 99);
         seq_no = {$urandom, $urandom};
         if (kind < 88) begin
            cnt = $urandom_range(1, 4);
            n_msgs = ($urandom_range(0, 4) == 0) ? $urandom_range(0, cnt - 1) : cnt;
            zero_at = (kind >= 80) ? $urandom_range(0, cnt - 1) : -1;
            start_header(seq_no, 16'(cnt));
            for (int i = 0; i < n_msgs; i++) begin
               len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
               if (i == zero_at)
                  len = 0;
               add_message(16'(len), len);
            end
            if ($urandom_range(0, 3) == 0)
               add_noise($urandom_range(1, 4));
            cut = (kind >= 60 && kind < 80) ? $urandom_range(1, datagram.size()) : 0;
            send_datagram(cut);
         end else if (kind < 94) begin
            start_header(seq_no, 16'($urandom_range(0, 65535)));
            add_message(16'($urandom_range(0, 65535)), $urandom_range(0, 30));
            send_datagram($urandom_range(1, datagram.size()));
         end else begin
            datagram.delete();
            add_noise($urandom_range(1, 30));
            send_datagram(0);
         end
      end
      req_valid <= 1'b0;

      while (sb.message_items.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
      if (sb.errors == 0 && sb.message_items.size() == 0)
         $display("packet_message_deframer_tb: done, clean");
      else
         $display("packet_message_deframer_tb: done, errors");
      $finish;
   end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/pmd_pkg.sv
rtl/core/pmd_parser.sv
rtl/core/pmd_out_buf.sv
rtl/core/packet_message_deframer.sv
tb/pmd_scoreboard_pkg.sv
tb/packet_message_deframer_tb.sv
